// ----- rtl/core/prsp_pkg.sv -----
// prsp_pkg: shared types and constants for the patch record stream parser
// result kinds, record types, error codes and the result item struct
// no dependencies
package prsp_pkg;

    typedef enum logic [3:0] {
        KIND_NAME      = 4'd0,
        KIND_START     = 4'd1,
        KIND_FILE_HDR  = 4'd2,
        KIND_DATA      = 4'd3,
        KIND_RB_HDR    = 4'd4,
        KIND_FILL      = 4'd5,
        KIND_COPY      = 4'd6,
        KIND_RB_END    = 4'd7,
        KIND_ERROR     = 4'd8
    } kind_t;

    localparam logic [1:0] RTYPE_FILE    = 2'd0;
    localparam logic [1:0] RTYPE_FOLDER  = 2'd1;
    localparam logic [1:0] RTYPE_REBUILD = 2'd2;
    localparam logic [1:0] RTYPE_DELETE  = 2'd3;

    localparam logic [1:0] ERR_NAME_LONG = 2'd0;
    localparam logic [1:0] ERR_BAD_TYPE  = 2'd1;
    localparam logic [1:0] ERR_TRUNC     = 2'd2;

    localparam logic [7:0] TYPE_FILE_BYTE    = 8'h00;
    localparam logic [7:0] TYPE_REBUILD_BYTE = 8'h01;
    localparam logic [7:0] TYPE_DELETE_BYTE  = 8'h02;
    localparam logic [7:0] SLASH_BYTE        = 8'h2F;
    localparam logic [7:0] BACKSLASH_BYTE    = 8'h5C;

    localparam logic [3:0]  CMD_LITERAL = 4'h8;
    localparam logic [3:0]  CMD_FILL    = 4'hC;
    localparam logic [27:0] LIT_MASK    = 28'h0FFFFFFF;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  value;
        logic [1:0]  record_type;
        logic [31:0] run_length;
        logic [31:0] old_offset;
        logic [31:0] check_first;
        logic [31:0] check_second;
        logic [1:0]  error_code;
        logic        stream_end;
    } prsp_result_t;

endpackage

// ----- rtl/core/prsp_step.sv -----
// prsp_step: parser state and per-item next-state logic
// consumes one body byte per accepted item and forms at most one result
// depends on prsp_pkg
module prsp_step
    import prsp_pkg::*;
#(
    parameter int MAX_NAME = 260
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   in_byte,
    input  logic         last_byte,
    output logic         res_valid,
    output prsp_result_t res
);

    localparam int NW = $clog2(MAX_NAME + 2);

    typedef enum logic [3:0] {
        PH_NAME     = 4'd0,
        PH_FILE_LEN = 4'd1,
        PH_FILE_SUM = 4'd2,
        PH_FILE_DAT = 4'd3,
        PH_RB_OLD   = 4'd4,
        PH_RB_NEW   = 4'd5,
        PH_RB_CMD   = 4'd6,
        PH_RB_LIT   = 4'd7,
        PH_RB_OFF   = 4'd8
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [31:0] gather_reg, gather_next;
    logic [1:0]  widx_reg, widx_next;
    logic [NW-1:0] name_len_reg, name_len_next;
    logic [7:0]  prev_byte_reg, prev_byte_next;
    logic [31:0] held_reg, held_next;
    logic [31:0] remain_reg, remain_next;
    logic [31:0] total_reg, total_next;
    logic        halted_reg, halted_next;

    logic [31:0] word_full;
    logic        word_done;
    logic        word_phase;
    logic [31:0] remain_dec;
    logic [31:0] total_add;
    logic [NW-1:0] name_len_inc;
    logic        have;
    logic        err;
    logic [1:0]  ecode;
    prsp_result_t norm;

    assign word_full    = gather_reg | ({24'd0, in_byte} << {widx_reg, 3'b000});
    assign word_done    = (widx_reg == 2'd3);
    assign remain_dec   = remain_reg - 32'd1;
    assign name_len_inc = name_len_reg + 1'b1;
    assign word_phase   = (phase_reg == PH_FILE_LEN) || (phase_reg == PH_FILE_SUM) ||
                          (phase_reg == PH_RB_OLD) || (phase_reg == PH_RB_NEW) ||
                          (phase_reg == PH_RB_CMD) || (phase_reg == PH_RB_OFF);

    always_comb
    begin
        phase_next     = phase_reg;
        gather_next    = gather_reg;
        widx_next      = widx_reg;
        name_len_next  = name_len_reg;
        prev_byte_next = prev_byte_reg;
        held_next      = held_reg;
        remain_next    = remain_reg;
        total_next     = total_reg;
        total_add      = 32'd0;
        have           = 1'b0;
        err            = 1'b0;
        ecode          = ERR_NAME_LONG;
        norm           = '0;
        norm.kind      = KIND_NAME;

        if (word_phase)
        begin
            if (word_done)
            begin
                gather_next = 32'd0;
                widx_next   = 2'd0;
            end
            else
            begin
                gather_next = word_full;
                widx_next   = widx_reg + 2'd1;
            end
        end

        unique case (phase_reg)
            PH_NAME:
            begin
                if (in_byte <= TYPE_DELETE_BYTE)
                begin
                    have      = 1'b1;
                    norm.kind = KIND_START;
                    if (in_byte == TYPE_FILE_BYTE)
                    begin
                        if (prev_byte_reg == SLASH_BYTE || prev_byte_reg == BACKSLASH_BYTE)
                        begin
                            norm.record_type = RTYPE_FOLDER;
                            phase_next       = PH_NAME;
                        end
                        else
                        begin
                            norm.record_type = RTYPE_FILE;
                            phase_next       = PH_FILE_LEN;
                        end
                    end
                    else if (in_byte == TYPE_REBUILD_BYTE)
                    begin
                        norm.record_type = RTYPE_REBUILD;
                        phase_next       = PH_RB_OLD;
                    end
                    else
                    begin
                        norm.record_type = RTYPE_DELETE;
                        phase_next       = PH_NAME;
                    end
                    name_len_next  = '0;
                    prev_byte_next = 8'd0;
                end
                else if (in_byte[7])
                begin
                    err   = 1'b1;
                    ecode = ERR_BAD_TYPE;
                end
                else
                begin
                    name_len_next = name_len_inc;
                    if (name_len_inc > NW'(MAX_NAME))
                    begin
                        err   = 1'b1;
                        ecode = ERR_NAME_LONG;
                    end
                    else
                    begin
                        prev_byte_next = in_byte;
                        have           = 1'b1;
                        norm.kind      = KIND_NAME;
                        norm.value     = in_byte;
                    end
                end
            end
            PH_FILE_LEN:
            begin
                if (word_done)
                begin
                    held_next  = word_full;
                    phase_next = PH_FILE_SUM;
                end
            end
            PH_FILE_SUM:
            begin
                if (word_done)
                begin
                    have             = 1'b1;
                    norm.kind        = KIND_FILE_HDR;
                    norm.run_length  = held_reg;
                    norm.check_first = word_full;
                    remain_next      = held_reg;
                    phase_next       = (held_reg != 32'd0) ? PH_FILE_DAT : PH_NAME;
                end
            end
            PH_FILE_DAT, PH_RB_LIT:
            begin
                have        = 1'b1;
                norm.kind   = KIND_DATA;
                norm.value  = in_byte;
                remain_next = remain_dec;
                if (remain_dec == 32'd0)
                begin
                    phase_next = (phase_reg == PH_FILE_DAT) ? PH_NAME : PH_RB_CMD;
                end
            end
            PH_RB_OLD:
            begin
                if (word_done)
                begin
                    held_next  = word_full;
                    phase_next = PH_RB_NEW;
                end
            end
            PH_RB_NEW:
            begin
                if (word_done)
                begin
                    have              = 1'b1;
                    norm.kind         = KIND_RB_HDR;
                    norm.check_first  = held_reg;
                    norm.check_second = word_full;
                    total_next        = 32'd0;
                    phase_next        = PH_RB_CMD;
                end
            end
            PH_RB_CMD:
            begin
                if (word_done)
                begin
                    if (word_full == 32'd0)
                    begin
                        have            = 1'b1;
                        norm.kind       = KIND_RB_END;
                        norm.run_length = total_reg;
                        phase_next      = PH_NAME;
                    end
                    else if (word_full[31:28] == CMD_LITERAL)
                    begin
                        total_add  = {4'd0, word_full[27:0] & LIT_MASK};
                        total_next = total_reg + total_add;
                        if (total_add != 32'd0)
                        begin
                            remain_next = total_add;
                            phase_next  = PH_RB_LIT;
                        end
                    end
                    else if (word_full[31:28] == CMD_FILL)
                    begin
                        total_add       = {12'd0, word_full[27:8]};
                        total_next      = total_reg + total_add;
                        have            = 1'b1;
                        norm.kind       = KIND_FILL;
                        norm.value      = word_full[7:0];
                        norm.run_length = total_add;
                    end
                    else
                    begin
                        total_add  = word_full;
                        total_next = total_reg + total_add;
                        held_next  = word_full;
                        phase_next = PH_RB_OFF;
                    end
                end
            end
            PH_RB_OFF:
            begin
                if (word_done)
                begin
                    have            = 1'b1;
                    norm.kind       = KIND_COPY;
                    norm.run_length = held_reg;
                    norm.old_offset = word_full;
                    phase_next      = PH_RB_CMD;
                end
            end
            default:
            begin
                phase_next = PH_NAME;
            end
        endcase

        halted_next = err || last_byte;

        res = norm;
        if (err)
        begin
            res            = '0;
            res.kind       = KIND_ERROR;
            res.error_code = ecode;
            res.stream_end = 1'b1;
        end
        else if (last_byte)
        begin
            if (phase_next != PH_NAME || !have)
            begin
                res            = '0;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_TRUNC;
            end
            res.stream_end = 1'b1;
        end
        res_valid = !halted_reg && (have || err || last_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_NAME;
            gather_reg    <= 32'd0;
            widx_reg      <= 2'd0;
            name_len_reg  <= '0;
            prev_byte_reg <= 8'd0;
            held_reg      <= 32'd0;
            remain_reg    <= 32'd0;
            total_reg     <= 32'd0;
            halted_reg    <= 1'b0;
        end
        else if (fire && !halted_reg)
        begin
            phase_reg     <= phase_next;
            gather_reg    <= gather_next;
            widx_reg      <= widx_next;
            name_len_reg  <= name_len_next;
            prev_byte_reg <= prev_byte_next;
            held_reg      <= held_next;
            remain_reg    <= remain_next;
            total_reg     <= total_next;
            halted_reg    <= halted_next;
        end
    end

    a_halted_silent: assert property (@(posedge clk) disable iff (!rst_n)
        halted_reg |-> !res_valid)
        else $error("result formed while halted");

    a_error_halts: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res_valid && res.kind == KIND_ERROR) |=> halted_reg)
        else $error("error result did not halt the parser");

    a_widx_in_word: assert property (@(posedge clk) disable iff (!rst_n)
        (widx_reg != 2'd0) |-> word_phase)
        else $error("partial word outside a word phase");

    a_name_bound: assert property (@(posedge clk) disable iff (!rst_n)
        !halted_reg |-> (name_len_reg <= NW'(MAX_NAME)))
        else $error("name length past limit while running");

endmodule

// ----- rtl/core/patch_record_stream_parser_core.sv -----
// patch record stream parser, top level
// usage: slave channel carries body bytes, master channel carries descriptor items
// one byte is accepted per cycle unless a held result stalls; the result is registered
// inputs: s_tdata is the body byte, s_tlast marks the final byte of the body
// outputs: m_tuser is the descriptor kind, m_tlast is set on the final result
// or on an error, m_tdata carries the descriptor fields
// a result appears on the master side in the cycle after its byte is accepted
// throughput: one byte per cycle while no result is held or the receiver takes it
// bytes that produce no descriptor (word bytes, literal commands) give no item
// a stalled receiver holds the output register; a new byte is still taken in the
// cycle the held result is taken, so a full-rate stream sees no bubbles
// after an error or the final byte the parser is halted: bytes are accepted and
// dropped until reset
// reset: asynchronous active low, parser returns to reading a record name
// depends on prsp_pkg and prsp_step
module patch_record_stream_parser_core
    import prsp_pkg::*;
#(
    parameter int MAX_NAME = 260
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,   // in_byte
    input  logic           s_tlast,   // last_byte
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [143:0]   m_tdata,   // value, record_type, run_length, old_offset,
                                      // check_first, check_second, error_code, zero pad
    output logic [3:0]     m_tuser,   // kind
    output logic           m_tlast    // stream_end
);

    logic         fire;
    logic         res_valid;
    prsp_result_t res;
    logic         out_valid_reg, out_valid_next;
    prsp_result_t out_reg;

    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;

    prsp_step #(
        .MAX_NAME (MAX_NAME)
    ) u_step (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .in_byte   (s_tdata),
        .last_byte (s_tlast),
        .res_valid (res_valid),
        .res       (res)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (fire)
        begin
            out_valid_next = res_valid;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.kind;
    assign m_tlast  = out_reg.stream_end;
    assign m_tdata  = {4'd0, out_reg.error_code, out_reg.check_second, out_reg.check_first,
                       out_reg.old_offset, out_reg.run_length, out_reg.record_type,
                       out_reg.value};

endmodule

// ----- sim/patch_record_stream_parser_core_tb.sv -----
// testbench for patch_record_stream_parser_core: one body of well-formed records with
// random content, an ending picked at random, predicted byte by byte and checked per field
// depends on prsp_pkg and the parser rtl
`timescale 1ns / 1ps

module patch_record_stream_parser_core_tb;
    import prsp_pkg::*;

    localparam int NAME_MAX    = 260;
    localparam int BODY_ITEMS  = 400;
    localparam int LIMIT       = 100000;
    localparam int HOLD_AT     = 150;
    localparam int HOLD_CYCLES = 100;
    localparam int QUIET_FROM  = 300;
    localparam int QUIET_TO    = 450;
    localparam int DRAIN       = 8;
    localparam logic [31:0] CMD_END = 32'h0;

    typedef enum logic [3:0] {
        PH_NAME, PH_FILE_LEN, PH_FILE_SUM, PH_FILE_DATA,
        PH_OLD_SUM, PH_NEW_SUM, PH_CMD, PH_LITERAL, PH_OFFSET
    } parse_phase_t;

    typedef struct packed {
        logic       last;
        logic [7:0] data;
    } body_byte_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = 8'h00;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [143:0] m_tdata;
    logic [3:0]   m_tuser;
    logic         m_tlast;

    body_byte_t   body_q[$];
    prsp_result_t descriptor_q[$];
    int           total_items = 0;
    int           accepted_cnt = 0;
    int           mismatch_cnt = 0;
    int           cyc = 0;
    int           hold_left = 0;
    logic         quiet;

    // parser state mirror
    parse_phase_t phase = PH_NAME;
    logic [31:0]  word_acc = '0;
    logic [1:0]   word_idx = '0;
    int           name_len = 0;
    logic [7:0]   prev_name = '0;
    logic [31:0]  held = '0;
    logic [31:0]  remaining = '0;
    logic [31:0]  rebuilt_total = '0;
    bit           halted = 1'b0;

    assign quiet = (cyc >= QUIET_FROM) && (cyc < QUIET_TO);

    patch_record_stream_parser_core #(
        .MAX_NAME (NAME_MAX)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    function automatic bit gather_word(input logic [7:0] b, output logic [31:0] w);
        w = '0;
        word_acc = word_acc | (32'(b) << (8 * word_idx));
        if (word_idx == 2'd3)
        begin
            w = word_acc;
            word_acc = '0;
            word_idx = '0;
            return 1'b1;
        end
        word_idx = word_idx + 2'd1;
        return 1'b0;
    endfunction

    function automatic bit parse_body_byte(input logic [7:0] b, input logic last,
                                           output prsp_result_t r);
        logic [31:0] w;
        logic [31:0] len;
        bit          have;
        bit          fail;
        logic [1:0]  code;
        r = '0;
        have = 1'b0;
        fail = 1'b0;
        code = ERR_NAME_LONG;
        if (halted)
            return 1'b0;
        case (phase)
            PH_NAME:
            begin
                if (b <= TYPE_DELETE_BYTE)
                begin
                    r.kind = KIND_START;
                    if (b == TYPE_FILE_BYTE)
                    begin
                        if (prev_name == SLASH_BYTE || prev_name == BACKSLASH_BYTE)
                        begin
                            r.record_type = RTYPE_FOLDER;
                            phase = PH_NAME;
                        end
                        else
                        begin
                            r.record_type = RTYPE_FILE;
                            phase = PH_FILE_LEN;
                        end
                    end
                    else if (b == TYPE_REBUILD_BYTE)
                    begin
                        r.record_type = RTYPE_REBUILD;
                        phase = PH_OLD_SUM;
                    end
                    else
                    begin
                        r.record_type = RTYPE_DELETE;
                        phase = PH_NAME;
                    end
                    have = 1'b1;
                    name_len = 0;
                    prev_name = '0;
                end
                else if (b[7])
                begin
                    fail = 1'b1;
                    code = ERR_BAD_TYPE;
                end
                else
                begin
                    name_len++;
                    if (name_len > NAME_MAX)
                    begin
                        fail = 1'b1;
                        code = ERR_NAME_LONG;
                    end
                    else
                    begin
                        prev_name = b;
                        r.kind = KIND_NAME;
                        r.value = b;
                        have = 1'b1;
                    end
                end
            end
            PH_FILE_LEN:
            begin
                if (gather_word(b, w))
                begin
                    held = w;
                    phase = PH_FILE_SUM;
                end
            end
            PH_FILE_SUM:
            begin
                if (gather_word(b, w))
                begin
                    r.kind = KIND_FILE_HDR;
                    r.run_length = held;
                    r.check_first = w;
                    have = 1'b1;
                    remaining = held;
                    phase = (held != 0) ? PH_FILE_DATA : PH_NAME;
                end
            end
            PH_FILE_DATA, PH_LITERAL:
            begin
                r.kind = KIND_DATA;
                r.value = b;
                have = 1'b1;
                remaining = remaining - 1;
                if (remaining == 0)
                    phase = (phase == PH_FILE_DATA) ? PH_NAME : PH_CMD;
            end
            PH_OLD_SUM:
            begin
                if (gather_word(b, w))
                begin
                    held = w;
                    phase = PH_NEW_SUM;
                end
            end
            PH_NEW_SUM:
            begin
                if (gather_word(b, w))
                begin
                    r.kind = KIND_RB_HDR;
                    r.check_first = held;
                    r.check_second = w;
                    have = 1'b1;
                    rebuilt_total = '0;
                    phase = PH_CMD;
                end
            end
            PH_CMD:
            begin
                if (gather_word(b, w))
                begin
                    if (w == CMD_END)
                    begin
                        r.kind = KIND_RB_END;
                        r.run_length = rebuilt_total;
                        have = 1'b1;
                        phase = PH_NAME;
                    end
                    else if (w[31:28] == CMD_LITERAL)
                    begin
                        len = {4'h0, w[27:0] & LIT_MASK};
                        rebuilt_total = rebuilt_total + len;
                        if (len != 0)
                        begin
                            remaining = len;
                            phase = PH_LITERAL;
                        end
                    end
                    else if (w[31:28] == CMD_FILL)
                    begin
                        len = {12'h0, w[27:8]};
                        rebuilt_total = rebuilt_total + len;
                        r.kind = KIND_FILL;
                        r.value = w[7:0];
                        r.run_length = len;
                        have = 1'b1;
                    end
                    else
                    begin
                        rebuilt_total = rebuilt_total + w;
                        held = w;
                        phase = PH_OFFSET;
                    end
                end
            end
            PH_OFFSET:
            begin
                if (gather_word(b, w))
                begin
                    r.kind = KIND_COPY;
                    r.run_length = held;
                    r.old_offset = w;
                    have = 1'b1;
                    phase = PH_CMD;
                end
            end
            default:
                phase = PH_NAME;
        endcase
        if (fail)
        begin
            r = '0;
            r.kind = KIND_ERROR;
            r.error_code = code;
            r.stream_end = 1'b1;
            halted = 1'b1;
            return 1'b1;
        end
        if (last)
        begin
            if (phase != PH_NAME || !have)
            begin
                r = '0;
                r.kind = KIND_ERROR;
                r.error_code = ERR_TRUNC;
            end
            r.stream_end = 1'b1;
            halted = 1'b1;
            return 1'b1;
        end
        return have;
    endfunction

    function automatic string fmt_result(input prsp_result_t r);
        return {$sformatf("kind %0d value %h type %0d run %h ",
                          r.kind, r.value, r.record_type, r.run_length),
                $sformatf("offset %h sum1 %h sum2 %h err %0d end %0b",
                          r.old_offset, r.check_first, r.check_second,
                          r.error_code, r.stream_end)};
    endfunction

    task automatic add_byte(input logic [7:0] b);
        body_byte_t item;
        item.data = b;
        item.last = 1'b0;
        body_q.push_back(item);
    endtask

    task automatic add_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++)
            add_byte(w[8*i +: 8]);
    endtask

    task automatic add_name(input int n, input bit folder);
        logic [7:0] b;
        for (int i = 0; i < n; i++)
        begin
            b = 8'($urandom_range(8'h7F, 8'h03));
            if (i == n - 1)
            begin
                if (folder)
                    b = $urandom_range(1) ? SLASH_BYTE : BACKSLASH_BYTE;
                else
                    while (b == SLASH_BYTE || b == BACKSLASH_BYTE)
                        b = 8'($urandom_range(8'h7F, 8'h03));
            end
            add_byte(b);
        end
    endtask

    task automatic add_record();
        int          pick;
        int          len;
        logic [31:0] w;
        pick = $urandom_range(99);
        if (pick < 35)
        begin
            add_name($urandom_range(12, 0), 1'b0);
            add_byte(TYPE_FILE_BYTE);
            len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(8);
            add_word(32'(len));
            add_word($urandom);
            repeat (len) add_byte(8'($urandom));
        end
        else if (pick < 50)
        begin
            add_name($urandom_range(12, 1), 1'b1);
            add_byte(TYPE_FILE_BYTE);
        end
        else if (pick < 65)
        begin
            add_name($urandom_range(12, 0), 1'b0);
            add_byte(TYPE_DELETE_BYTE);
        end
        else
        begin
            add_name($urandom_range(12, 0), 1'b0);
            add_byte(TYPE_REBUILD_BYTE);
            add_word($urandom);
            add_word($urandom);
            repeat ($urandom_range(5, 1))
            begin
                pick = $urandom_range(2);
                if (pick == 0)
                begin
                    len = $urandom_range(6);
                    add_word({CMD_LITERAL, 28'(len)});
                    repeat (len) add_byte(8'($urandom));
                end
                else if (pick == 1)
                    add_word({CMD_FILL, 20'($urandom), 8'($urandom)});
                else
                begin
                    do
                        w = $urandom;
                    while (w == CMD_END || w[31:28] == CMD_LITERAL || w[31:28] == CMD_FILL);
                    add_word(w);
                    add_word($urandom);
                end
            end
            add_word(CMD_END);
        end
    endtask

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        int pick;
        int start;
        int cut;
        // empty-name file of length zero
        add_byte(TYPE_FILE_BYTE);
        add_word(32'h0);
        add_word(32'hFFFF_FFFF);
        // folders ending in slash and backslash, delete with extreme name bytes
        add_byte(SLASH_BYTE);
        add_byte(TYPE_FILE_BYTE);
        add_byte(BACKSLASH_BYTE);
        add_byte(TYPE_FILE_BYTE);
        add_byte(8'h03);
        add_byte(8'h7F);
        add_byte(TYPE_DELETE_BYTE);
        // rebuild with zero-length fill and literal
        add_byte(TYPE_REBUILD_BYTE);
        add_word(32'h0);
        add_word(32'hFFFF_FFFF);
        add_word({CMD_FILL, 20'h0, 8'hFF});
        add_word({CMD_LITERAL, 28'h0});
        add_word(CMD_END);

        while (body_q.size() < BODY_ITEMS)
            add_record();

        pick = $urandom_range(99);
        if (pick < 40)
            body_q[body_q.size() - 1].last = 1'b1;
        else if (pick < 70)
        begin
            start = body_q.size();
            add_record();
            cut = $urandom_range(body_q.size() - 1, start);
            while (body_q.size() > cut + 1)
                void'(body_q.pop_back());
            body_q[body_q.size() - 1].last = 1'b1;
        end
        else if (pick < 85)
        begin
            add_name($urandom_range(5), 1'b0);
            add_byte(8'($urandom_range(255, 128)));
            body_q[body_q.size() - 1].last = 1'($urandom_range(1));
        end
        else
            add_name(NAME_MAX + 1, 1'b0);

        // bytes after the end are taken and dropped
        repeat ($urandom_range(4, 1))
        begin
            add_byte(8'($urandom));
            body_q[body_q.size() - 1].last = 1'($urandom_range(1));
        end
        total_items = body_q.size();

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        while (accepted_cnt != total_items)
            @(posedge clk);
        while (descriptor_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN) @(posedge clk);
        if (mismatch_cnt == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        cyc <= cyc + 1;
        if (cyc == LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        body_byte_t nxt;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'h00;
            s_tlast  <= 1'b0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (body_q.size() != 0 && (quiet || $urandom_range(99) >= 12))
            begin
                nxt = body_q.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= nxt.data;
                s_tlast  <= nxt.last;
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    // long receiver hold-off so the output stalls and backs up the input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready  <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (cyc == HOLD_AT)
                hold_left <= HOLD_CYCLES;
            else if (hold_left != 0)
                hold_left <= hold_left - 1;
            if (cyc == HOLD_AT || hold_left > 1)
                m_tready <= 1'b0;
            else if (quiet)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(99) >= 12);
        end
    end

    always @(posedge clk)
    begin
        prsp_result_t want;
        prsp_result_t got;
        string        bad;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                if (parse_body_byte(s_tdata, s_tlast, want))
                    descriptor_q.push_back(want);
                accepted_cnt++;
            end
            if (m_tvalid && m_tready)
            begin
                got.kind         = kind_t'(m_tuser);
                got.value        = m_tdata[7:0];
                got.record_type  = m_tdata[9:8];
                got.run_length   = m_tdata[41:10];
                got.old_offset   = m_tdata[73:42];
                got.check_first  = m_tdata[105:74];
                got.check_second = m_tdata[137:106];
                got.error_code   = m_tdata[139:138];
                got.stream_end   = m_tlast;
                if (descriptor_q.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("%0t: item with nothing expected: %s", $time,
                                 fmt_result(got));
                end
                else
                begin
                    want = descriptor_q.pop_front();
                    bad = "";
                    if (got.kind !== want.kind)                 bad = {bad, " kind"};
                    if (got.value !== want.value)               bad = {bad, " value"};
                    if (got.record_type !== want.record_type)   bad = {bad, " record_type"};
                    if (got.run_length !== want.run_length)     bad = {bad, " run_length"};
                    if (got.old_offset !== want.old_offset)     bad = {bad, " old_offset"};
                    if (got.check_first !== want.check_first)   bad = {bad, " check_first"};
                    if (got.check_second !== want.check_second) bad = {bad, " check_second"};
                    if (got.error_code !== want.error_code)     bad = {bad, " error_code"};
                    if (got.stream_end !== want.stream_end)     bad = {bad, " stream_end"};
                    if (bad != "")
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                        begin
                            $display("%0t: mismatch in%s", $time, bad);
                            $display("  expected %s", fmt_result(want));
                            $display("  actual   %s", fmt_result(got));
                        end
                    end
                end
            end
        end
    end

endmodule
